[rtl/flru_pkg.sv]
package flru_pkg;

    // Field widths fixed by the item format
    localparam int SEL_W  = 6;
    localparam int WORD_W = 32;

    // Data returned for an empty or out-of-range line
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_WRITE  = 2'd2,
        FUNC_LOOKUP = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMP  = 2'd1,
        ST_RES  = 2'd2
    } state_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              eval;
        logic              commit;
        logic              full;
        func_t             func;
        logic [SEL_W-1:0]  line_sel;
        logic [WORD_W-1:0] mem_address;
        logic [WORD_W-1:0] wdata;
    } cell_cmd_t;

endpackage

[rtl/flru_cell.sv]
module flru_cell
    import flru_pkg::*;
#(
    parameter int LINE_COUNT = 64,
    parameter int INDEX      = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_cmd_t                     cmd,
    input  logic [$clog2(LINE_COUNT)-1:0] fill_idx,
    input  logic [$clog2(LINE_COUNT)-1:0] tgt_rank,
    input  logic                          prior_in,
    output logic                          prior_out,
    output logic                          pick,
    output logic [WORD_W-1:0]             data_out,
    output logic [$clog2(LINE_COUNT)-1:0] rank_out
);

    localparam int IDX_W = $clog2(LINE_COUNT);
    localparam int CMP_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(LINE_COUNT - 1);

    logic              valid_reg;
    logic              valid_next;
    logic [IDX_W-1:0]  rank_reg;
    logic [IDX_W-1:0]  rank_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] addr_next;
    logic              flag_reg;
    logic              flag_next;

    // Local candidate flag, sampled in the compare cycle
    always_comb
    begin
        flag_next = flag_reg;
        if (cmd.eval)
        begin
            unique case (cmd.func)
                FUNC_INSERT:
                    flag_next = cmd.full ? (rank_reg == '0) : (fill_idx == MY_IDX);
                FUNC_READ, FUNC_WRITE:
                    flag_next = valid_reg && (CMP_W'(MY_IDX) == CMP_W'(cmd.line_sel));
                FUNC_LOOKUP:
                    flag_next = valid_reg && (addr_reg == cmd.mem_address);
                default:
                    flag_next = 1'b0;
            endcase
        end
    end

    // Priority chain: lowest flagged cell wins
    assign pick      = flag_reg && !prior_in;
    assign prior_out = prior_in || flag_reg;
    assign data_out  = pick ? data_reg : '0;
    assign rank_out  = pick ? rank_reg : '0;

    // Line update and recency shift on commit
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        data_next  = data_reg;
        addr_next  = addr_reg;
        if (cmd.commit)
        begin
            if (pick)
            begin
                rank_next = TOP_RANK;
                if (cmd.func == FUNC_INSERT)
                begin
                    valid_next = 1'b1;
                    data_next  = cmd.wdata;
                    addr_next  = cmd.mem_address;
                end
                else if (cmd.func == FUNC_WRITE)
                begin
                    data_next = cmd.wdata;
                end
            end
            else if (rank_reg > tgt_rank)
            begin
                rank_next = rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= MY_IDX;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            flag_reg  <= flag_next;
        end
    end

    // Line contents carry no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        addr_reg <= addr_next;
    end

endmodule

[rtl/fully_associative_lru_cache.sv]
// Fully associative cache of LINE_COUNT lines with exact LRU replacement. Each line
// is a cell in a chain holding its valid bit, data word, address and recency rank.
// Insert fills the lowest empty line (lines fill in order, tracked by a fill count),
// or else the least recently used line, and reports it; read and write access a line
// by number, lookup reports the lowest valid line holding the address. Insert, read
// and write make the line the most recent. An item is accepted, all cells compare in
// parallel in the next cycle, then in the resolve state the priority chain picks
// the line and its data and rank are gathered; once the output can take the result,
// ranks shift and the result is registered. The next item is taken in that same
// cycle, so a new item is accepted only as the previous one finishes. No clearing
// pass is needed after reset.
module fully_associative_lru_cache
    import flru_pkg::*;
#(
    parameter int LINE_COUNT = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [SEL_W-1:0]         line_sel,
    input  logic [WORD_W-1:0]        mem_address,
    input  logic signed [WORD_W-1:0] wdata,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SEL_W-1:0]         line_out,
    output logic signed [WORD_W-1:0] rdata,
    output logic                     found
);

    localparam int IDX_W  = $clog2(LINE_COUNT);
    localparam int FILL_W = $clog2(LINE_COUNT + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_COUNT);

    state_t             state_reg;
    state_t             state_next;
    func_t              func_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [WORD_W-1:0]  addr_reg;
    logic [WORD_W-1:0]  wdata_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SEL_W-1:0]   line_out_reg;
    logic [SEL_W-1:0]   line_out_next;
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  rdata_next;
    logic               found_reg;
    logic               found_next;

    logic               accept;
    logic               can_commit;
    logic               finish;
    logic               full;
    logic               any_pick;
    cell_cmd_t          cmd;
    logic [LINE_COUNT:0]     prior;
    logic [LINE_COUNT-1:0]   picks;
    logic [WORD_W-1:0]       cell_data [LINE_COUNT];
    logic [IDX_W-1:0]        cell_rank [LINE_COUNT];
    logic [WORD_W-1:0]       data_g;
    logic [IDX_W-1:0]        rank_g;
    logic [IDX_W-1:0]        index_g;

    // Handshake
    assign full       = (fill_reg == FILL_MAX);
    assign can_commit = !out_valid_reg || !out_stall;
    assign finish     = (state_reg == ST_RES) && can_commit;
    assign in_stall   = !((state_reg == ST_IDLE) || finish);
    assign accept     = in_valid && !in_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_CMP;
            ST_CMP:
                state_next = ST_RES;
            ST_RES:
                if (finish)
                    state_next = accept ? ST_CMP : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Broadcast to the chain
    always_comb
    begin
        cmd.eval        = (state_reg == ST_CMP);
        cmd.commit      = finish && (func_reg != FUNC_LOOKUP) && any_pick;
        cmd.full        = full;
        cmd.func        = func_reg;
        cmd.line_sel    = sel_reg;
        cmd.mem_address = addr_reg;
        cmd.wdata       = wdata_reg;
    end

    // Chain of line cells
    assign prior[0] = 1'b0;
    assign any_pick = prior[LINE_COUNT];

    for (genvar g = 0; g < LINE_COUNT; g++)
    begin : g_cell
        flru_cell #(
            .LINE_COUNT (LINE_COUNT),
            .INDEX      (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .fill_idx  (IDX_W'(fill_reg)),
            .tgt_rank  (rank_g),
            .prior_in  (prior[g]),
            .prior_out (prior[g+1]),
            .pick      (picks[g]),
            .data_out  (cell_data[g]),
            .rank_out  (cell_rank[g])
        );
    end

    // Gather the picked line's data, rank and number
    always_comb
    begin
        data_g  = '0;
        rank_g  = '0;
        index_g = '0;
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            data_g = data_g | cell_data[i];
            rank_g = rank_g | cell_rank[i];
            if (picks[i])
                index_g = index_g | IDX_W'(i);
        end
    end

    // Result formation
    always_comb
    begin
        line_out_next = '0;
        rdata_next    = '0;
        found_next    = 1'b0;
        case (func_reg)
            FUNC_INSERT:
            begin
                line_out_next = SEL_W'(index_g);
                found_next    = 1'b1;
            end
            FUNC_READ, FUNC_WRITE:
            begin
                rdata_next = any_pick ? data_g : EMPTY_WORD;
                found_next = any_pick;
            end
            default:
            begin
                line_out_next = any_pick ? SEL_W'(index_g) : '0;
                found_next    = any_pick;
            end
        endcase
    end

    // Output register and fill count
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;

        fill_next = fill_reg;
        if (cmd.commit && (func_reg == FUNC_INSERT) && !full)
            fill_next = fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(func);
            sel_reg   <= line_sel;
            addr_reg  <= mem_address;
            wdata_reg <= wdata;
        end
        if (finish)
        begin
            line_out_reg <= line_out_next;
            rdata_reg    <= rdata_next;
            found_reg    <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_out  = line_out_reg;
    assign rdata     = $signed(rdata_reg);
    assign found     = found_reg;

`ifndef ASSERT_OFF
    // A committed access touches exactly one line
    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $onehot(picks))
        else $error("commit without a single picked line");

    // Insert always finds a victim
    a_insert_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES && func_reg == FUNC_INSERT) |-> any_pick)
        else $error("insert found no victim line");

    // Insert into a cache that is not full advances the fill count
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && func_reg == FUNC_INSERT && !full)
            |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance on insert");

    // A result only appears after the resolve cycle
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RES))
        else $error("result raised outside the resolve cycle");
`endif

endmodule
